>>> src/script_line_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Script line sequencer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LINE_SEQUENCER_MACROS_SVH
`define SCRIPT_LINE_SEQUENCER_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define SLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, checked through reset as well
`define SLS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> src/sls_pkg.sv
// ----------------------------------------------------------------------------
// Script line sequencer package
// Widths, command and error codes, state and datapath types.
// ----------------------------------------------------------------------------
package sls_pkg;

   // Field widths of the request and response
   localparam int LINE_W    = 9;
   localparam int LINE_MAX  = (2 ** LINE_W) - 1;
   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 4;
   localparam int FLAG_W    = 3;
   localparam int LADDR_W   = 8;
   localparam int SLOT_W    = 8;
   localparam int ERR_W     = 3;

   // Parameter defaults
   localparam int DEF_MAX_LINES  = 256;
   localparam int DEF_CALL_DEPTH = 16;
   localparam int DEF_LOOP_DEPTH = 8;

   // Bit positions inside a line's flags
   localparam int FLAG_IF     = 0;
   localparam int FLAG_ENDIF  = 1;
   localparam int FLAG_ENDFOR = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESTART = 4'd0,
      CMD_LOAD    = 4'd1,
      CMD_ADVANCE = 4'd2,
      CMD_GOTO    = 4'd3,
      CMD_CALL    = 4'd4,
      CMD_RETURN  = 4'd5,
      CMD_FOR     = 4'd6,
      CMD_NEXT    = 4'd7,
      CMD_BREAK   = 4'd8,
      CMD_SKIP_IF = 4'd9
   } cmd_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 3'd0,
      ERR_CALL_EMPTY = 3'd1,
      ERR_ZERO_STEP  = 3'd2,
      ERR_CALL_FULL  = 3'd3,
      ERR_LOOP_FULL  = 3'd4
   } err_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RET_DATA,
      ST_NXT_ADD,
      ST_NXT_CMP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FINISH
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               neg;
   } alu_res_type;

   typedef struct packed {
      logic [LINE_W-1:0]         begin_line;
      logic signed [VALUE_W-1:0] current;
      logic signed [VALUE_W-1:0] bound;
      logic signed [VALUE_W-1:0] increment;
      logic [SLOT_W-1:0]         owner;
   } loop_entry_type;

endpackage

>>> src/sls_channels.sv
// ----------------------------------------------------------------------------
// Script line sequencer channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface sls_req_if;
   logic                              valid;
   logic                              ready;
   logic [sls_pkg::CMD_W-1:0]         command;
   logic [sls_pkg::LADDR_W-1:0]       line_address;
   logic [sls_pkg::FLAG_W-1:0]        line_flags;
   logic [sls_pkg::LADDR_W-1:0]       target_line;
   logic [sls_pkg::SLOT_W-1:0]        variable_slot;
   logic signed [sls_pkg::VALUE_W-1:0] first_value;
   logic signed [sls_pkg::VALUE_W-1:0] last_value;
   logic signed [sls_pkg::VALUE_W-1:0] step_value;

   modport source (
      output valid, command, line_address, line_flags, target_line,
             variable_slot, first_value, last_value, step_value,
      input  ready
   );
   modport sink (
      input  valid, command, line_address, line_flags, target_line,
             variable_slot, first_value, last_value, step_value,
      output ready
   );
endinterface

interface sls_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sls_pkg::LINE_W-1:0]        next_line;
   logic                              halted;
   logic [sls_pkg::ERR_W-1:0]         error_code;
   logic signed [sls_pkg::VALUE_W-1:0] loop_value;
   logic                              loop_value_valid;
   logic [sls_pkg::SLOT_W-1:0]        loop_variable;

   modport source (
      output valid, next_line, halted, error_code, loop_value,
             loop_value_valid, loop_variable,
      input  ready
   );
   modport sink (
      input  valid, next_line, halted, error_code, loop_value,
             loop_value_valid, loop_variable,
      output ready
   );
endinterface

>>> src/sls_alu.sv
// ----------------------------------------------------------------------------
// Script line sequencer shared adder
// 33-bit add/subtract on sign-extended operands; the sign of a difference
// gives the signed compare used by the loop test.
// ----------------------------------------------------------------------------
module sls_alu (
   input  sls_pkg::alu_ctl_type                ctl,
   input  logic signed [sls_pkg::VALUE_W-1:0]  op_a,
   input  logic signed [sls_pkg::VALUE_W-1:0]  op_b,
   output sls_pkg::alu_res_type                res
);
   import sls_pkg::*;

   logic               is_sub;
   logic [VALUE_W:0]   ext_a;
   logic [VALUE_W:0]   ext_b;
   logic [VALUE_W:0]   total;

   // Invert and carry in for subtract
   assign is_sub = (ctl.op == ALU_SUB);
   assign ext_a  = {op_a[VALUE_W-1], op_a};
   assign ext_b  = is_sub ? ~{op_b[VALUE_W-1], op_b} : {op_b[VALUE_W-1], op_b};
   assign total  = ext_a + ext_b + {{VALUE_W{1'b0}}, is_sub};

   assign res.sum = total[VALUE_W-1:0];
   assign res.neg = total[VALUE_W];

endmodule

>>> src/script_line_sequencer.sv
// ----------------------------------------------------------------------------
// Script line sequencer
// Line counter, call stack, counted-loop stack and IF/ENDIF/ENDFOR flag
// store of a line-based script interpreter.
// ----------------------------------------------------------------------------
// One request at a time; req ready drops from acceptance until the result is
// in the response register, which may still wait for the sink while the next
// request is taken. Restart, load flags, advance, goto, call and FOR pass
// through the execute and finish states; return adds a state that pops the
// call stack read; NEXT adds an add state and a compare state after the loop
// stack read, in which the shared 33-bit adder forms current + step and then
// compares it against the bound. BREAK and skip-to-ENDIF scan the flag store
// forward, a read state and a check state per line through its registered
// read port, and finish from the read state when the scan runs off the end of
// the program. After reset the flag store is cleared one line per cycle over
// all MAX_LINES lines, during which no request is taken; csr writes are taken
// at any time.
// ----------------------------------------------------------------------------
module script_line_sequencer #(
   parameter int MAX_LINES  = sls_pkg::DEF_MAX_LINES,
   parameter int CALL_DEPTH = sls_pkg::DEF_CALL_DEPTH,
   parameter int LOOP_DEPTH = sls_pkg::DEF_LOOP_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [sls_pkg::LINE_W-1:0]  csr_write_data,
   sls_req_if.sink                     req_ch,
   sls_rsp_if.source                   rsp_ch
);
   import sls_pkg::*;

   localparam int ADDR_W     = $clog2(MAX_LINES);
   localparam int CALL_W     = $clog2(CALL_DEPTH);
   localparam int CALL_CNT_W = $clog2(CALL_DEPTH + 1);
   localparam int LOOP_W     = $clog2(LOOP_DEPTH);
   localparam int LOOP_CNT_W = $clog2(LOOP_DEPTH + 1);
   localparam int LEN_CAP_I  = (MAX_LINES > LINE_MAX) ? LINE_MAX : MAX_LINES;
   localparam logic [LINE_W-1:0]     LEN_CAP   = LINE_W'(LEN_CAP_I);
   localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(MAX_LINES - 1);
   localparam logic [CALL_CNT_W-1:0] CALL_FULL = CALL_CNT_W'(CALL_DEPTH);
   localparam logic [LOOP_CNT_W-1:0] LOOP_FULL = LOOP_CNT_W'(LOOP_DEPTH);

   // Sequencer
   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_idx_ff, clr_idx_in;

   // Held request
   cmd_type                   cmd_ff, cmd_in;
   logic [LADDR_W-1:0]        addr_ff, addr_in;
   logic [FLAG_W-1:0]         flags_ff, flags_in;
   logic [LADDR_W-1:0]        target_ff, target_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic signed [VALUE_W-1:0] first_ff, first_in;
   logic signed [VALUE_W-1:0] last_ff, last_in;
   logic signed [VALUE_W-1:0] step_ff, step_in;

   // Architectural state
   logic [LINE_W-1:0]     program_length_ff, program_length_in;
   logic [LINE_W-1:0]     lc_ff, lc_in;
   logic                  stopped_ff, stopped_in;
   err_type               err_ff, err_in;
   logic [CALL_CNT_W-1:0] rdepth_ff, rdepth_in;
   logic [LOOP_CNT_W-1:0] ldepth_ff, ldepth_in;

   // Working registers
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic [LINE_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [LINE_W-1:0]         scan_depth_ff, scan_depth_in;
   logic signed [VALUE_W-1:0] lval_ff, lval_in;
   logic [SLOT_W-1:0]         lvar_ff, lvar_in;
   logic                      lvalid_ff, lvalid_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0]         rsp_line_ff;
   logic                      rsp_halted_ff;
   err_type                   rsp_err_ff;
   logic signed [VALUE_W-1:0] rsp_lval_ff;
   logic                      rsp_lvalid_ff;
   logic [SLOT_W-1:0]         rsp_lvar_ff;
   logic                      out_free;
   logic                      out_load;

   // Memories
   logic [FLAG_W-1:0]  flag_mem [MAX_LINES];
   logic [FLAG_W-1:0]  flag_rd_ff;
   logic               flag_we;
   logic [ADDR_W-1:0]  flag_wa;
   logic [FLAG_W-1:0]  flag_wd;
   logic [ADDR_W-1:0]  flag_ra;

   logic [LINE_W-1:0]  call_mem [CALL_DEPTH];
   logic [LINE_W-1:0]  call_rd_ff;
   logic               call_we;
   logic [CALL_W-1:0]  call_wa;
   logic [CALL_W-1:0]  call_ra;

   loop_entry_type     loop_mem [LOOP_DEPTH];
   loop_entry_type     loop_rd_ff;
   logic               loop_we;
   logic [LOOP_W-1:0]  loop_wa;
   loop_entry_type     loop_wd;
   logic [LOOP_W-1:0]  loop_ra;

   // Shared adder
   alu_ctl_type               alu_ctl;
   logic signed [VALUE_W-1:0] alu_a;
   logic signed [VALUE_W-1:0] alu_b;
   alu_res_type               alu_res;

   // Decode helpers
   logic [LINE_W-1:0] used_len;
   logic              exec_live;
   logic              scan_hit;
   logic              inc_up;
   logic              inc_down;
   logic              nxt_done;

   sls_alu u_alu (
      .ctl  (alu_ctl),
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   // Clamp the program length to the flag store size
   assign used_len  = (program_length_ff > LEN_CAP) ? LEN_CAP : program_length_ff;

   // Commands 2..9 run only on a live counter
   assign exec_live = (cmd_ff != CMD_RESTART) && (cmd_ff != CMD_LOAD) &&
                      !stopped_ff && (lc_ff < used_len);

   // Scan match on the flags just read
   assign scan_hit = (cmd_ff == CMD_BREAK) ? flag_rd_ff[FLAG_ENDFOR] :
                     (!flag_rd_ff[FLAG_IF] && flag_rd_ff[FLAG_ENDIF] &&
                      (scan_depth_ff <= LINE_W'(1)));

   // Loop end test from the shared adder's difference
   assign inc_up   = !loop_rd_ff.increment[VALUE_W-1] && (loop_rd_ff.increment != '0);
   assign inc_down = loop_rd_ff.increment[VALUE_W-1];
   assign nxt_done = (inc_up || inc_down) && !alu_res.neg;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = (state_ff == ST_FINISH) && out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign flag_ra = ADDR_W'(scan_idx_ff);
   assign call_ra = CALL_W'(rdepth_ff - 1'b1);
   assign loop_ra = LOOP_W'(ldepth_ff - 1'b1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            if (exec_live) begin
               case (cmd_ff)
                  CMD_RETURN: begin
                     if (rdepth_ff != '0) begin
                        state_in = ST_RET_DATA;
                     end
                  end
                  CMD_NEXT: begin
                     if (ldepth_ff != '0) begin
                        state_in = ST_NXT_ADD;
                     end
                  end
                  CMD_BREAK: begin
                     if (ldepth_ff != '0) begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  CMD_SKIP_IF: begin
                     state_in = ST_SCAN_RD;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RET_DATA: state_in = ST_FINISH;
         ST_NXT_ADD:  state_in = ST_NXT_CMP;
         ST_NXT_CMP:  state_in = ST_FINISH;
         ST_SCAN_RD: begin
            state_in = (scan_idx_ff >= used_len) ? ST_FINISH : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = scan_hit ? ST_FINISH : ST_SCAN_RD;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      logic              set_line;
      logic [LINE_W-1:0] new_line;

      set_line          = 1'b0;
      new_line          = lc_ff;
      clr_idx_in        = clr_idx_ff;
      cmd_in            = cmd_ff;
      addr_in           = addr_ff;
      flags_in          = flags_ff;
      target_in         = target_ff;
      slot_in           = slot_ff;
      first_in          = first_ff;
      last_in           = last_ff;
      step_in           = step_ff;
      program_length_in = csr_write_enable ? csr_write_data : program_length_ff;
      lc_in             = lc_ff;
      stopped_in        = stopped_ff;
      err_in            = err_ff;
      rdepth_in         = rdepth_ff;
      ldepth_in         = ldepth_ff;
      acc_in            = acc_ff;
      scan_idx_in       = scan_idx_ff;
      scan_depth_in     = scan_depth_ff;
      lval_in           = lval_ff;
      lvar_in           = lvar_ff;
      lvalid_in         = lvalid_ff;
      flag_we           = 1'b0;
      flag_wa           = clr_idx_ff;
      flag_wd           = '0;
      call_we           = 1'b0;
      call_wa           = CALL_W'(rdepth_ff);
      loop_we           = 1'b0;
      loop_wa           = LOOP_W'(ldepth_ff);
      loop_wd           = loop_rd_ff;
      alu_ctl.op        = ALU_ADD;
      alu_a             = loop_rd_ff.current;
      alu_b             = loop_rd_ff.increment;

      case (state_ff)
         ST_CLEAR: begin
            // Sweep zeros through the flag store
            flag_we    = 1'b1;
            flag_wa    = clr_idx_ff;
            flag_wd    = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
         end
         ST_IDLE: begin
            // Hold the accepted request
            if (req_ch.valid) begin
               cmd_in    = cmd_type'(req_ch.command);
               addr_in   = req_ch.line_address;
               flags_in  = req_ch.line_flags;
               target_in = req_ch.target_line;
               slot_in   = req_ch.variable_slot;
               first_in  = req_ch.first_value;
               last_in   = req_ch.last_value;
               step_in   = req_ch.step_value;
            end
         end
         ST_EXEC: begin
            lval_in       = '0;
            lvar_in       = '0;
            lvalid_in     = 1'b0;
            scan_idx_in   = lc_ff;
            scan_depth_in = '0;
            case (cmd_ff)
               CMD_RESTART: begin
                  lc_in      = '0;
                  stopped_in = (used_len == '0);
                  err_in     = ERR_NONE;
                  rdepth_in  = '0;
                  ldepth_in  = '0;
               end
               CMD_LOAD: begin
                  if (int'(addr_ff) < MAX_LINES) begin
                     flag_we = 1'b1;
                     flag_wa = ADDR_W'(addr_ff);
                     flag_wd = flags_ff;
                  end
               end
               default: begin
                  if (!stopped_ff) begin
                     if (lc_ff >= used_len) begin
                        stopped_in = 1'b1;
                     end else begin
                        case (cmd_ff)
                           CMD_GOTO: begin
                              set_line = 1'b1;
                              new_line = LINE_W'(target_ff);
                           end
                           CMD_CALL: begin
                              if (rdepth_ff >= CALL_FULL) begin
                                 stopped_in = 1'b1;
                                 err_in     = ERR_CALL_FULL;
                              end else begin
                                 call_we   = 1'b1;
                                 rdepth_in = rdepth_ff + 1'b1;
                                 set_line  = 1'b1;
                                 new_line  = LINE_W'(target_ff);
                              end
                           end
                           CMD_RETURN: begin
                              if (rdepth_ff == '0) begin
                                 stopped_in = 1'b1;
                                 err_in     = ERR_CALL_EMPTY;
                              end
                           end
                           CMD_FOR: begin
                              if (step_ff == '0) begin
                                 stopped_in = 1'b1;
                                 err_in     = ERR_ZERO_STEP;
                              end else if (ldepth_ff >= LOOP_FULL) begin
                                 stopped_in = 1'b1;
                                 err_in     = ERR_LOOP_FULL;
                              end else begin
                                 // Push a new loop frame
                                 loop_we            = 1'b1;
                                 loop_wd.begin_line = lc_ff + 1'b1;
                                 loop_wd.current    = first_ff;
                                 loop_wd.bound      = last_ff;
                                 loop_wd.increment  = step_ff;
                                 loop_wd.owner      = slot_ff;
                                 ldepth_in          = ldepth_ff + 1'b1;
                                 lval_in            = first_ff;
                                 lvar_in            = slot_ff;
                                 lvalid_in          = 1'b1;
                                 set_line           = 1'b1;
                                 new_line           = lc_ff + 1'b1;
                              end
                           end
                           CMD_NEXT: begin
                              if (ldepth_ff == '0) begin
                                 set_line = 1'b1;
                                 new_line = lc_ff + 1'b1;
                              end
                           end
                           CMD_BREAK: begin
                              if (ldepth_ff == '0) begin
                                 set_line = 1'b1;
                                 new_line = lc_ff + 1'b1;
                              end else begin
                                 ldepth_in = ldepth_ff - 1'b1;
                              end
                           end
                           CMD_SKIP_IF: begin
                              set_line = 1'b0;
                           end
                           default: begin
                              set_line = 1'b1;
                              new_line = lc_ff + 1'b1;
                           end
                        endcase
                     end
                  end
               end
            endcase
         end
         ST_RET_DATA: begin
            // Pop the return line
            rdepth_in = rdepth_ff - 1'b1;
            set_line  = 1'b1;
            new_line  = call_rd_ff;
         end
         ST_NXT_ADD: begin
            alu_ctl.op = ALU_ADD;
            alu_a      = loop_rd_ff.current;
            alu_b      = loop_rd_ff.increment;
            acc_in     = signed'(alu_res.sum);
         end
         ST_NXT_CMP: begin
            // Counting down compares bound - next, counting up next - bound
            alu_ctl.op = ALU_SUB;
            if (inc_down) begin
               alu_a = loop_rd_ff.bound;
               alu_b = acc_ff;
            end else begin
               alu_a = acc_ff;
               alu_b = loop_rd_ff.bound;
            end
            set_line = 1'b1;
            if (nxt_done) begin
               ldepth_in = ldepth_ff - 1'b1;
               new_line  = lc_ff + 1'b1;
            end else begin
               loop_we         = 1'b1;
               loop_wa         = loop_ra;
               loop_wd.current = acc_ff;
               lval_in         = acc_ff;
               lvar_in         = loop_rd_ff.owner;
               lvalid_in       = 1'b1;
               new_line        = loop_rd_ff.begin_line;
            end
         end
         ST_SCAN_RD: begin
            // Drop to line 0 when the scan runs off the program
            if (scan_idx_ff >= used_len) begin
               set_line = 1'b1;
               new_line = '0;
            end
         end
         ST_SCAN_CHK: begin
            if (scan_hit) begin
               set_line = 1'b1;
               new_line = scan_idx_ff + 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               if (cmd_ff == CMD_SKIP_IF) begin
                  if (flag_rd_ff[FLAG_IF]) begin
                     scan_depth_in = scan_depth_ff + 1'b1;
                  end else if (flag_rd_ff[FLAG_ENDIF]) begin
                     scan_depth_in = scan_depth_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            set_line = 1'b0;
         end
      endcase

      // Move the counter and halt past the program end
      if (set_line) begin
         lc_in      = new_line;
         stopped_in = (new_line >= used_len);
      end
   end

   // Advance the response register
   always_comb begin
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_idx_ff        <= '0;
         program_length_ff <= '0;
         lc_ff             <= '0;
         stopped_ff        <= 1'b0;
         err_ff            <= ERR_NONE;
         rdepth_ff         <= '0;
         ldepth_ff         <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_idx_ff        <= clr_idx_in;
         program_length_ff <= program_length_in;
         lc_ff             <= lc_in;
         stopped_ff        <= stopped_in;
         err_ff            <= err_in;
         rdepth_ff         <= rdepth_in;
         ldepth_ff         <= ldepth_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      flags_ff      <= flags_in;
      target_ff     <= target_in;
      slot_ff       <= slot_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      scan_idx_ff   <= scan_idx_in;
      scan_depth_ff <= scan_depth_in;
      lval_ff       <= lval_in;
      lvar_ff       <= lvar_in;
      lvalid_ff     <= lvalid_in;
      if (out_load) begin
         rsp_line_ff   <= lc_ff;
         rsp_halted_ff <= stopped_ff;
         rsp_err_ff    <= err_ff;
         rsp_lval_ff   <= lval_ff;
         rsp_lvalid_ff <= lvalid_ff;
         rsp_lvar_ff   <= lvar_ff;
      end
   end

   // Flag store
   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[flag_ra];
   end

   // Call stack
   always_ff @(posedge clock) begin
      if (call_we) begin
         call_mem[call_wa] <= lc_ff + 1'b1;
      end
      call_rd_ff <= call_mem[call_ra];
   end

   // Loop stack
   always_ff @(posedge clock) begin
      if (loop_we) begin
         loop_mem[loop_wa] <= loop_wd;
      end
      loop_rd_ff <= loop_mem[loop_ra];
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.next_line        = rsp_line_ff;
   assign rsp_ch.halted           = rsp_halted_ff;
   assign rsp_ch.error_code       = rsp_err_ff;
   assign rsp_ch.loop_value       = rsp_lval_ff;
   assign rsp_ch.loop_value_valid = rsp_lvalid_ff;
   assign rsp_ch.loop_variable    = rsp_lvar_ff;

endmodule

>>> src/sls_checker.sv
// ----------------------------------------------------------------------------
// Script line sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "script_line_sequencer_macros.svh"

module sls_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sls_pkg::LINE_W-1:0]        rsp_next_line,
   input logic                              rsp_halted,
   input logic [sls_pkg::ERR_W-1:0]         rsp_error_code,
   input logic signed [sls_pkg::VALUE_W-1:0] rsp_loop_value,
   input logic                              rsp_loop_value_valid,
   input logic [sls_pkg::SLOT_W-1:0]        rsp_loop_variable
);
   import sls_pkg::*;

   logic req_seen;

   // Request handshake, used by the flag clear check
   assign req_seen = req_valid && req_ready;

   // Hold a stalled response
   `SLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_line) && $stable(rsp_error_code) && $stable(rsp_loop_value), "stalled response changed")

   // A recorded error always comes with a halt
   `SLS_ASSERT_IMPLY(a_err_halts, clock, reset, rsp_valid && (rsp_error_code != ERR_NONE), rsp_halted, "error without halt")

   // A loop write happens only on an error-free line
   `SLS_ASSERT_IMPLY(a_loop_no_err, clock, reset, rsp_valid && rsp_loop_value_valid, rsp_error_code == ERR_NONE, "loop write with error")

   // No loop write leaves the loop fields at zero
   `SLS_ASSERT_IMPLY(a_loop_idle, clock, reset, rsp_valid && !rsp_loop_value_valid, (rsp_loop_value == '0) && (rsp_loop_variable == '0), "loop fields not cleared")

   // The flag store clear blocks requests on the first cycle out of reset
   `SLS_ASSERT_IMPLY(a_clear_blocks, clock, reset, $past(reset), !req_ready && !req_seen, "request taken during flag clear")

endmodule

bind script_line_sequencer sls_checker u_sls_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_next_line        (rsp_ch.next_line),
   .rsp_halted           (rsp_ch.halted),
   .rsp_error_code       (rsp_ch.error_code),
   .rsp_loop_value       (rsp_ch.loop_value),
   .rsp_loop_value_valid (rsp_ch.loop_value_valid),
   .rsp_loop_variable    (rsp_ch.loop_variable)
);

>>> test/script_line_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script line sequencer testbench
// Drives a short table of directed requests, then random script phases with
// flag loads, jumps, calls and counted loops. Every request is run through a
// line-level predictor, and each response is compared field by field with
// the oldest prediction. Both channels stall at random, and the program
// length changes between phases.
// ----------------------------------------------------------------------------
module script_line_sequencer_tb;
   import sls_pkg::*;

   localparam int LINE_CAP    = DEF_MAX_LINES;
   localparam int CALL_CAP    = DEF_CALL_DEPTH;
   localparam int LOOP_CAP    = DEF_LOOP_DEPTH;
   localparam int ITEM_GOAL   = 1850;
   localparam int CYCLE_LIMIT = 4_500_000;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [LADDR_W-1:0] line_address;
      logic [FLAG_W-1:0]  line_flags;
      logic [LADDR_W-1:0] target_line;
      logic [SLOT_W-1:0]  variable_slot;
      logic [VALUE_W-1:0] first_value;
      logic [VALUE_W-1:0] last_value;
      logic [VALUE_W-1:0] step_value;
   } line_cmd_type;

   typedef struct packed {
      logic [LINE_W-1:0]  next_line;
      logic               halted;
      logic [ERR_W-1:0]   error_code;
      logic [VALUE_W-1:0] loop_value;
      logic               loop_value_valid;
      logic [SLOT_W-1:0]  loop_variable;
   } line_result_type;

   typedef struct {
      bit                is_csr;
      logic [LINE_W-1:0] csr_value;
      line_cmd_type      cmd;
      bit                typed;
      line_result_type   want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic [LINE_W-1:0] csr_write_data;

   sls_req_if req_bus ();
   sls_rsp_if rsp_bus ();

   script_line_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus)
   );

   // Predicted sequencer state
   logic [LINE_W-1:0]         length_reg;
   int                        pc;
   bit                        halted_st;
   err_type                   fault;
   logic [FLAG_W-1:0]         line_flag_mem [LINE_CAP];
   logic [LINE_W-1:0]         return_lines [CALL_CAP];
   int                        call_level;
   logic [LINE_W-1:0]         loop_head [LOOP_CAP];
   logic signed [VALUE_W-1:0] loop_count [LOOP_CAP];
   logic signed [VALUE_W-1:0] loop_limit [LOOP_CAP];
   logic signed [VALUE_W-1:0] loop_step [LOOP_CAP];
   logic [SLOT_W-1:0]         loop_var [LOOP_CAP];
   int                        loop_level;

   line_result_type pending_lines [$];
   dir_row_type     dir_table [$];
   int              sent_commands  = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   bit              quiet_run      = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int active_lines();
      return (length_reg > LINE_CAP) ? LINE_CAP : int'(length_reg);
   endfunction

   // Line after the first ENDFOR at or past the counter, else line 0
   function automatic int find_endfor();
      int n;
      n = active_lines();
      for (int i = pc; i < n; i++)
         if (line_flag_mem[i][FLAG_ENDFOR]) return i + 1;
      return 0;
   endfunction

   // Line after the matching ENDIF; a line with both bits nests as an IF
   function automatic int find_endif();
      int n;
      int nest;
      n = active_lines();
      nest = 0;
      for (int i = pc; i < n; i++) begin
         if (line_flag_mem[i][FLAG_IF]) begin
            nest++;
         end else if (line_flag_mem[i][FLAG_ENDIF]) begin
            if (nest == 0) return i + 1;
            nest--;
            if (nest == 0) return i + 1;
         end
      end
      return 0;
   endfunction

   function automatic void raise_fault(err_type code);
      halted_st = 1'b1;
      fault = code;
   endfunction

   // Execute one request against the predicted state
   function automatic line_result_type execute_line(line_cmd_type c);
      line_result_type           r;
      int                        n;
      int                        t;
      logic signed [VALUE_W-1:0] nxt;
      bit                        done;
      r = '0;
      n = active_lines();
      case (c.command)
         CMD_RESTART: begin
            pc = 0;
            halted_st = 1'b0;
            fault = ERR_NONE;
            call_level = 0;
            loop_level = 0;
            if (pc >= n) halted_st = 1'b1;
         end
         CMD_LOAD: line_flag_mem[c.line_address] = c.line_flags;
         default: begin
            if (!halted_st) begin
               if (pc >= n) begin
                  halted_st = 1'b1;
               end else begin
                  case (c.command)
                     CMD_GOTO: pc = c.target_line;
                     CMD_CALL: begin
                        if (call_level >= CALL_CAP) begin
                           raise_fault(ERR_CALL_FULL);
                        end else begin
                           return_lines[call_level] = LINE_W'(pc + 1);
                           call_level++;
                           pc = c.target_line;
                        end
                     end
                     CMD_RETURN: begin
                        if (call_level == 0) begin
                           raise_fault(ERR_CALL_EMPTY);
                        end else begin
                           call_level--;
                           pc = return_lines[call_level];
                        end
                     end
                     CMD_FOR: begin
                        if (c.step_value == '0) begin
                           raise_fault(ERR_ZERO_STEP);
                        end else if (loop_level >= LOOP_CAP) begin
                           raise_fault(ERR_LOOP_FULL);
                        end else begin
                           loop_head[loop_level]  = LINE_W'(pc + 1);
                           loop_count[loop_level] = c.first_value;
                           loop_limit[loop_level] = c.last_value;
                           loop_step[loop_level]  = c.step_value;
                           loop_var[loop_level]   = c.variable_slot;
                           loop_level++;
                           r.loop_value = c.first_value;
                           r.loop_variable = c.variable_slot;
                           r.loop_value_valid = 1'b1;
                           pc++;
                        end
                     end
                     CMD_NEXT: begin
                        if (loop_level == 0) begin
                           pc++;
                        end else begin
                           t = loop_level - 1;
                           nxt = loop_count[t] + loop_step[t];
                           done = (loop_step[t] > 0 && nxt >= loop_limit[t]) ||
                                  (loop_step[t] < 0 && nxt <= loop_limit[t]);
                           if (done) begin
                              loop_level--;
                              pc++;
                           end else begin
                              loop_count[t] = nxt;
                              r.loop_value = nxt;
                              r.loop_variable = loop_var[t];
                              r.loop_value_valid = 1'b1;
                              pc = loop_head[t];
                           end
                        end
                     end
                     CMD_BREAK: begin
                        if (loop_level == 0) begin
                           pc++;
                        end else begin
                           loop_level--;
                           pc = find_endfor();
                        end
                     end
                     CMD_SKIP_IF: pc = find_endif();
                     default: pc++;
                  endcase
                  if (!halted_st && pc >= n) halted_st = 1'b1;
               end
            end
         end
      endcase
      r.next_line = LINE_W'(pc);
      r.halted = halted_st;
      r.error_code = fault;
      return r;
   endfunction

   // Present one request, hold it until taken, then record its prediction
   task automatic issue_command(line_cmd_type c, bit typed, line_result_type typed_res);
      line_result_type r;
      quiet_run = (sent_commands >= 700 && sent_commands < 1000);
      while (!quiet_run && $urandom_range(99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= c.command;
      req_bus.line_address  <= c.line_address;
      req_bus.line_flags    <= c.line_flags;
      req_bus.target_line   <= c.target_line;
      req_bus.variable_slot <= c.variable_slot;
      req_bus.first_value   <= c.first_value;
      req_bus.last_value    <= c.last_value;
      req_bus.step_value    <= c.step_value;
      // Ready only moves at the rising edge, so its value mid-cycle is the one taken
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      r = execute_line(c);
      pending_lines = {pending_lines, (typed ? typed_res : r)};
      sent_commands++;
   endtask

   // Drain all responses, then write the program length
   task automatic set_program_length(logic [LINE_W-1:0] v);
      req_bus.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_reg = v;
   endtask

   function automatic dir_row_type csr_row(logic [LINE_W-1:0] v);
      dir_row_type d;
      d = '{default: '0};
      d.is_csr = 1'b1;
      d.csr_value = v;
      return d;
   endfunction

   function automatic dir_row_type cmd_row(logic [CMD_W-1:0] op, logic [LADDR_W-1:0] target,
                                           logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] first,
                                           logic [VALUE_W-1:0] last, logic [VALUE_W-1:0] step);
      dir_row_type d;
      d = '{default: '0};
      d.cmd.command = op;
      d.cmd.target_line = target;
      d.cmd.variable_slot = slot;
      d.cmd.first_value = first;
      d.cmd.last_value = last;
      d.cmd.step_value = step;
      return d;
   endfunction

   function automatic dir_row_type fixed_row(logic [CMD_W-1:0] op, logic [LADDR_W-1:0] addr,
                                             logic [FLAG_W-1:0] flags,
                                             logic [LADDR_W-1:0] target,
                                             int line, bit halt, err_type err);
      dir_row_type d;
      d = '{default: '0};
      d.cmd.command = op;
      d.cmd.line_address = addr;
      d.cmd.line_flags = flags;
      d.cmd.target_line = target;
      d.typed = 1'b1;
      d.want.next_line = LINE_W'(line);
      d.want.halted = halt;
      d.want.error_code = err;
      return d;
   endfunction

   // Mostly plain lines, with IF, ENDIF and ENDFOR markers sprinkled in
   function automatic logic [FLAG_W-1:0] random_flags();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return '0;
      if (roll < 68) return FLAG_W'(1 << FLAG_IF);
      if (roll < 81) return FLAG_W'(1 << FLAG_ENDIF);
      if (roll < 93) return FLAG_W'(1 << FLAG_ENDFOR);
      return FLAG_W'($urandom_range(7));
   endfunction

   function automatic logic [VALUE_W-1:0] extreme_value();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Pick the next script command; flood 1 piles up calls, flood 2 loops
   function automatic line_cmd_type choose_command(int flood);
      line_cmd_type c;
      int           span;
      int           roll;
      int           f;
      int           s;
      c.command       = CMD_ADVANCE;
      c.line_address  = LADDR_W'($urandom_range(255));
      c.line_flags    = random_flags();
      c.target_line   = LADDR_W'($urandom_range(255));
      c.variable_slot = SLOT_W'($urandom_range(255));
      c.first_value   = $urandom;
      c.last_value    = $urandom;
      c.step_value    = $urandom;
      span = active_lines();
      if (span > 0 && $urandom_range(99) < 85) c.target_line = LADDR_W'($urandom_range(span - 1));
      roll = $urandom_range(99);
      // Halted: mostly restart, sometimes poke it to see it hold
      if (halted_st) begin
         if (roll < 75) c.command = CMD_RESTART;
         else if (roll < 85) c.command = CMD_LOAD;
         else c.command = CMD_W'($urandom_range(15));
         return c;
      end
      if (flood == 1 && roll < 70) begin
         c.command = CMD_CALL;
      end else if (flood == 2 && roll < 60) begin
         c.command = CMD_FOR;
      end else begin
         roll = $urandom_range(99);
         if (roll < 3) c.command = CMD_RESTART;
         else if (roll < 7) c.command = CMD_LOAD;
         else if (roll < 20) c.command = CMD_ADVANCE;
         else if (roll < 28) c.command = CMD_GOTO;
         else if (roll < 40) c.command = CMD_CALL;
         else if (roll < 52) c.command = CMD_RETURN;
         else if (roll < 64) c.command = CMD_FOR;
         else if (roll < 82) c.command = CMD_NEXT;
         else if (roll < 88) c.command = CMD_BREAK;
         else if (roll < 96) c.command = CMD_SKIP_IF;
         else c.command = CMD_W'($urandom_range(15, 10));
      end
      // Shape loop bounds so most loops run a few passes
      if (c.command == CMD_FOR) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            f = int'($urandom_range(20)) - 10;
            s = int'($urandom_range(3, 1));
            if ($urandom_range(1) != 0) s = -s;
            c.first_value = f;
            c.step_value  = s;
            c.last_value  = f + s * int'($urandom_range(5)) + int'($urandom_range(2)) - 1;
         end else if (roll < 72) begin
            c.first_value = extreme_value();
            c.last_value  = extreme_value();
            c.step_value  = extreme_value();
         end else if (roll < 76) begin
            c.step_value = '0;
         end
      end
      return c;
   endfunction

   // One script run: set the length, restart, load flags, then execute
   task automatic run_script_phase(logic [LINE_W-1:0] length_setting, int flood, int steps);
      line_cmd_type c;
      int           span;
      set_program_length(length_setting);
      c = '0;
      c.command = CMD_RESTART;
      issue_command(c, 1'b0, '0);
      span = active_lines();
      c.command = CMD_LOAD;
      if (span <= 64) begin
         for (int i = 0; i < span; i++) begin
            c.line_address = LADDR_W'(i);
            c.line_flags = random_flags();
            issue_command(c, 1'b0, '0);
         end
      end else begin
         repeat (24) begin
            c.line_address = LADDR_W'($urandom_range(255));
            c.line_flags = random_flags();
            issue_command(c, 1'b0, '0);
         end
      end
      repeat (steps) issue_command(choose_command(flood), 1'b0, '0);
   endtask

   task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Response side: stall at random and check each response taken
   initial begin
      line_result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         // Look mid-cycle at what the next rising edge will take
         @(negedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_lines.size() == 0) begin
               $error("response with no request outstanding, next_line %0d", rsp_bus.next_line);
               mismatch_count++;
            end else begin
               want = pending_lines.pop_front();
               check_field("next_line", want.next_line, rsp_bus.next_line);
               check_field("halted", want.halted, rsp_bus.halted);
               check_field("error_code", want.error_code, rsp_bus.error_code);
               check_field("loop_value", want.loop_value, rsp_bus.loop_value);
               check_field("loop_value_valid", want.loop_value_valid, rsp_bus.loop_value_valid);
               check_field("loop_variable", want.loop_variable, rsp_bus.loop_variable);
            end
         end
         @(posedge clock);
         rsp_bus.ready <= quiet_run || ($urandom_range(99) >= 16);
      end
   end

   // Request side: directed table, then random script phases
   initial begin
      int               phase;
      int               flood;
      logic [LINE_W-1:0] len;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.line_address = '0;
      req_bus.line_flags = '0;
      req_bus.target_line = '0;
      req_bus.variable_slot = '0;
      req_bus.first_value = '0;
      req_bus.last_value = '0;
      req_bus.step_value = '0;
      length_reg = '0;
      pc = 0;
      halted_st = 1'b0;
      fault = ERR_NONE;
      call_level = 0;
      loop_level = 0;
      foreach (line_flag_mem[i]) line_flag_mem[i] = '0;

      // Lines 3 IF, 5 IF+ENDIF, 6 and 7 ENDIF, 9 ENDFOR in a 12-line script
      dir_table = '{
         fixed_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b1, ERR_NONE),   // zero length halts
         fixed_row(CMD_LOAD, 255, 7, 0, 0, 1'b1, ERR_NONE),    // load while halted
         csr_row(12),
         fixed_row(CMD_LOAD, 3, 1, 0, 0, 1'b1, ERR_NONE),
         fixed_row(CMD_LOAD, 5, 3, 0, 0, 1'b1, ERR_NONE),
         fixed_row(CMD_LOAD, 6, 2, 0, 0, 1'b1, ERR_NONE),
         fixed_row(CMD_LOAD, 7, 2, 0, 0, 1'b1, ERR_NONE),
         fixed_row(CMD_LOAD, 9, 4, 0, 0, 1'b1, ERR_NONE),
         fixed_row(CMD_RESTART, 0, 0, 0, 0, 1'b0, ERR_NONE),
         cmd_row(CMD_SKIP_IF, 0, 0, 0, 0, 0),                 // nested IFs
         cmd_row(CMD_GOTO, 6, 0, 0, 0, 0),
         cmd_row(CMD_SKIP_IF, 0, 0, 0, 0, 0),                 // ENDIF at depth zero
         cmd_row(CMD_CALL, 10, 0, 0, 0, 0),
         cmd_row(CMD_RETURN, 0, 0, 0, 0, 0),
         fixed_row(CMD_RETURN, 0, 0, 0, 8, 1'b1, ERR_CALL_EMPTY),
         fixed_row(CMD_ADVANCE, 0, 0, 0, 8, 1'b1, ERR_CALL_EMPTY),
         fixed_row(CMD_RESTART, 0, 0, 0, 0, 1'b0, ERR_NONE),
         cmd_row(CMD_FOR, 0, 255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000),
         cmd_row(CMD_NEXT, 0, 0, 0, 0, 0),                    // wraps through zero
         cmd_row(CMD_NEXT, 0, 0, 0, 0, 0),
         cmd_row(CMD_BREAK, 0, 0, 0, 0, 0),
         cmd_row(CMD_NEXT, 0, 0, 0, 0, 0),                    // no loop open
         fixed_row(CMD_FOR, 0, 0, 0, 11, 1'b1, ERR_ZERO_STEP),
         fixed_row(CMD_RESTART, 0, 0, 0, 0, 1'b0, ERR_NONE),
         cmd_row(4'hF, 0, 0, 0, 0, 0),                        // unknown acts as advance
         cmd_row(CMD_BREAK, 0, 0, 0, 0, 0),
         fixed_row(CMD_GOTO, 0, 0, 255, 255, 1'b1, ERR_NONE)  // jump off the end
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].is_csr) set_program_length(dir_table[i].csr_value);
         else issue_command(dir_table[i].cmd, dir_table[i].typed, dir_table[i].want);
      end

      // Random phases; the first few hit the length extremes
      phase = 0;
      while (sent_commands < ITEM_GOAL) begin
         flood = 0;
         case (phase)
            0: len = 256;
            1: len = 1;
            2: len = 0;
            3: len = 511;
            4: len = 257;
            default: begin
               case ($urandom_range(19))
                  0: len = 0;
                  1: len = 1;
                  2: len = 256;
                  3: len = LINE_W'($urandom_range(511, 257));
                  default: len = LINE_W'($urandom_range(48, 4));
               endcase
               if (phase % 6 == 4 || phase % 6 == 5) begin
                  flood = (phase % 6 == 4) ? 1 : 2;
                  len = LINE_W'($urandom_range(64, 40));
               end
            end
         endcase
         run_script_phase(len, flood, 60);
         phase++;
      end

      req_bus.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
